// ===== rtl/brm_pkg.sv =====
`default_nettype none

package brm_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int POINT_DEPTH = 16;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int NCNT_W = $clog2(MAX_SLOTS + 1);
    localparam int QA_W   = $clog2(POINT_DEPTH);
    localparam int QCNT_W = $clog2(POINT_DEPTH + 1);

    localparam int POS_W   = 14;
    localparam int LVL_W   = 16;
    localparam int BS_W    = 15;
    localparam int PER_W   = 9;
    localparam int CFG_W   = 16;
    localparam int DIV_W   = 16;
    localparam int DEN_W   = 14;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int DIFF_W  = LVL_W + 1;
    localparam int ACC_W   = DIV_W + DIFF_W + 1;
    localparam int QENT_W  = POS_W + LVL_W;

    localparam logic [1:0] CFG_BLOCK_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_PERIOD        = 2'd1;
    localparam logic [1:0] CFG_INIT_LEVEL    = 2'd2;

    localparam logic [1:0] CMD_RENDER = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic [POS_W-1:0]         sample_offset;
        logic signed [LVL_W-1:0]  level_value;
    } t_in;

    typedef struct packed {
        logic signed [LVL_W-1:0]  level;
        logic [SLOT_W-1:0]        slot_index;
        logic                     last_slot;
    } t_out;

    typedef struct packed {
        logic               start;
        logic [DEN_W-1:0]   rem_init;
        logic [DIV_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               step;
        logic               qbit;
        logic               done;
        logic [DIV_W-1:0]   quot;
    } t_div_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_DIV,
        S_CNT_DIV,
        S_POP_RD,
        S_POP_CHK,
        S_SLOT_GO,
        S_SLOT_DIV,
        S_SLOT_WR,
        S_FILL_CHK,
        S_FILL,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/brm_ram.sv =====
`default_nettype none

module brm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wa,
    input  wire logic [WIDTH-1:0]         i_wd,
    input  wire logic [$clog2(DEPTH)-1:0] i_ra,
    output logic      [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

`default_nettype wire

// ===== rtl/brm_sdiv.sv =====
`default_nettype none

module brm_sdiv
    import brm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_stat      o_stat
);

    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic [DEN_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_quot;

    logic [DEN_W:0]    x;
    logic [DEN_W+1:0]  diff;
    logic              qb;
    logic [DEN_W-1:0]  n_rem;
    logic              busy;

    // restoring division, one quotient bit per cycle, MSB first
    always_comb begin
        x     = {r_rem, r_num[DIV_W-1]};
        diff  = {1'b0, x} - {2'b00, r_den};
        qb    = ~diff[DEN_W+1];
        n_rem = qb ? diff[DEN_W-1:0] : x[DEN_W-1:0];
        busy  = (r_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DCNT_W'(DIV_W);
            end else if (busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (busy) begin
            r_rem  <= n_rem;
            r_num  <= {r_num[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], qb};
        end
    end

    assign o_stat.step = busy;
    assign o_stat.qbit = qb;
    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/brm_mac.sv =====
`default_nettype none

module brm_mac
    import brm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_clr,
    input  wire logic                      i_step,
    input  wire logic                      i_qbit,
    input  wire logic signed [DIFF_W-1:0]  i_diff,
    output logic signed [ACC_W-1:0]        o_acc
);

    logic signed [ACC_W-1:0] addend;

    // t * diff built from quotient bits as they leave the divider
    always_comb begin
        addend = i_qbit ? ACC_W'(i_diff) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            o_acc <= '0;
        end else if (i_step) begin
            o_acc <= (o_acc <<< 1) + addend;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/breakpoint_ramp_modulator.sv =====
// Add: a 16-step offset/period division, or none if the queue is full and it is dropped. Set is code 2.
// Render: a division for the slot count, a read and check per queued point, a division and
// write per ramped slot, the fill check, a write per held slot, then a read and load per
// result out of the slot buffer, held under stall. One request at a time; the serial divider sets the per-slot cost.
// Synchronous active-low reset: state and configuration back to defaults, queue empty, level 0.
// No clearing pass; queue and slot buffer are written before read.
`default_nettype none

module breakpoint_ramp_modulator
    import brm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in               i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out                   o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [BS_W-1:0]          r_bs, n_bs;
    logic [PER_W-1:0]         r_per, n_per;
    logic signed [LVL_W-1:0]  r_init, n_init;
    logic signed [LVL_W-1:0]  r_cur, n_cur;
    logic [QA_W-1:0]          r_head, n_head;
    logic [QCNT_W-1:0]        r_count, n_count;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [NCNT_W-1:0]        r_n, n_n;
    logic [SLOT_W-1:0]        r_j, n_j;
    logic [POS_W-1:0]         r_k, n_k;
    logic [POS_W-1:0]         r_s, n_s;
    logic signed [LVL_W-1:0]  r_v, n_v;
    logic                     r_out_vld, n_out_vld;
    t_out                     r_out, n_out;

    t_div_req                 div_req;
    t_div_stat                div_stat;
    logic                     mac_clr;
    logic signed [DIFF_W-1:0] mac_diff;
    logic signed [ACC_W-1:0]  mac_acc;

    logic                     q_we;
    logic [QA_W-1:0]          q_wa;
    logic [QENT_W-1:0]        q_rd;
    logic                     s_we;
    logic [LVL_W-1:0]         s_wd;
    logic [LVL_W-1:0]         s_rd;

    logic                     in_acc;
    logic                     q_full;
    logic [PER_W-1:0]         eff_per;
    logic [POS_W-1:0]         off_c;
    logic [QCNT_W:0]          tail_sum;
    logic [POS_W-1:0]         pop_s;
    logic [POS_W-1:0]         den;
    logic [NCNT_W-1:0]        j_inc;
    logic                     more_slots;
    logic                     pos_lt_n;
    logic                     out_load;
    logic [ACC_W-1:0]         rnd;
    logic signed [LVL_W+1:0]  lvl_w;
    logic signed [LVL_W-1:0]  lvl_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        q_full   = (r_count >= QCNT_W'(POINT_DEPTH));
        eff_per  = (r_per == '0) ? PER_W'(1) : r_per;
        if (r_bs == '0) begin
            off_c = '0;
        end else if ({1'b0, i_in_data.sample_offset} >= r_bs) begin
            off_c = POS_W'(r_bs - BS_W'(1));
        end else begin
            off_c = i_in_data.sample_offset;
        end
        tail_sum = {1'b0, (QCNT_W)'(r_head)} + {1'b0, r_count};
        if (tail_sum >= (QCNT_W+1)'(POINT_DEPTH)) begin
            tail_sum = tail_sum - (QCNT_W+1)'(POINT_DEPTH);
        end
        q_wa       = tail_sum[QA_W-1:0];
        pop_s      = q_rd[QENT_W-1:LVL_W];
        den        = r_s - r_pos;
        j_inc      = {1'b0, r_j} + NCNT_W'(1);
        more_slots = ({(POS_W-NCNT_W)'(0), j_inc} < r_s) && (j_inc < r_n);
        pos_lt_n   = (r_pos < {(POS_W-NCNT_W)'(0), r_n});
        out_load   = (r_state == S_EMIT_LD) && (!r_out_vld || !i_out_stall);
        mac_diff   = DIFF_W'(r_v) - DIFF_W'(r_cur);
        rnd        = mac_acc + ACC_W'(32'sd32768);
        lvl_w      = (LVL_W+2)'(r_cur) + $signed(rnd[ACC_W-1:DIV_W]);
        if (lvl_w > (LVL_W+2)'(32767)) begin
            lvl_sat = 16'sh7FFF;
        end else if (lvl_w < -(LVL_W+2)'(32768)) begin
            lvl_sat = -16'sh8000;
        end else begin
            lvl_sat = lvl_w[LVL_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.command)
                        CMD_ADD:    n_state = q_full ? S_IDLE : S_ADD_DIV;
                        CMD_RENDER: n_state = S_CNT_DIV;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_DIV: begin
                if (div_stat.done) n_state = S_IDLE;
            end
            S_CNT_DIV: begin
                if (div_stat.done) n_state = (r_count != '0) ? S_POP_RD : S_FILL_CHK;
            end
            S_POP_RD: n_state = S_POP_CHK;
            S_POP_CHK: begin
                if (pop_s > r_pos && pos_lt_n) begin
                    n_state = S_SLOT_GO;
                end else begin
                    n_state = (r_count == QCNT_W'(1)) ? S_FILL_CHK : S_POP_RD;
                end
            end
            S_SLOT_GO: n_state = S_SLOT_DIV;
            S_SLOT_DIV: begin
                if (div_stat.done) n_state = S_SLOT_WR;
            end
            S_SLOT_WR: begin
                if (more_slots) begin
                    n_state = S_SLOT_GO;
                end else begin
                    n_state = (r_count == '0) ? S_FILL_CHK : S_POP_RD;
                end
            end
            S_FILL_CHK: begin
                if (pos_lt_n) begin
                    n_state = S_FILL;
                end else begin
                    n_state = (r_n != '0) ? S_EMIT_RD : S_IDLE;
                end
            end
            S_FILL: begin
                if (j_inc == r_n) n_state = S_EMIT_RD;
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (out_load) n_state = (j_inc == r_n) ? S_IDLE : S_EMIT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_bs      = r_bs;
        n_per     = r_per;
        n_init    = r_init;
        n_cur     = r_cur;
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_n       = r_n;
        n_j       = r_j;
        n_k       = r_k;
        n_s       = r_s;
        n_v       = r_v;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        div_req   = '0;
        mac_clr   = 1'b0;
        q_we      = 1'b0;
        s_we      = 1'b0;
        s_wd      = r_cur;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.command)
                        CMD_ADD: begin
                            n_v              = i_in_data.level_value;
                            div_req.start    = !q_full;
                            div_req.num      = {(DIV_W-POS_W)'(0), off_c};
                            div_req.den      = {(DEN_W-PER_W)'(0), eff_per};
                        end
                        CMD_RENDER: begin
                            div_req.start    = 1'b1;
                            div_req.num      = {(DIV_W-BS_W)'(0), r_bs};
                            div_req.den      = {(DEN_W-PER_W)'(0), eff_per};
                        end
                        CMD_SET: begin
                            n_cur   = i_in_data.level_value;
                            n_head  = '0;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_DIV: begin
                if (div_stat.done) begin
                    q_we    = 1'b1;
                    n_count = r_count + QCNT_W'(1);
                end
            end
            S_CNT_DIV: begin
                if (div_stat.done) begin
                    n_pos = '0;
                    if (div_stat.quot > DIV_W'(MAX_SLOTS)) begin
                        n_n = NCNT_W'(MAX_SLOTS);
                    end else begin
                        n_n = div_stat.quot[NCNT_W-1:0];
                    end
                end
            end
            S_POP_RD: ;
            S_POP_CHK: begin
                n_head  = (r_head == QA_W'(POINT_DEPTH - 1)) ? '0 : r_head + QA_W'(1);
                n_count = r_count - QCNT_W'(1);
                n_s     = pop_s;
                n_v     = q_rd[LVL_W-1:0];
                n_j     = r_pos[SLOT_W-1:0];
                n_k     = '0;
                if (!(pop_s > r_pos && pos_lt_n)) begin
                    n_cur = q_rd[LVL_W-1:0];
                    n_pos = pop_s;
                end
            end
            S_SLOT_GO: begin
                mac_clr          = 1'b1;
                div_req.start    = 1'b1;
                div_req.rem_init = r_k;
                div_req.num      = {(DIV_W-POS_W+1)'(0), den[POS_W-1:1]};
                div_req.den      = den;
            end
            S_SLOT_DIV: ;
            S_SLOT_WR: begin
                s_we = 1'b1;
                s_wd = lvl_sat;
                n_j  = j_inc[SLOT_W-1:0];
                n_k  = r_k + POS_W'(1);
                if (!more_slots) begin
                    n_cur = r_v;
                    n_pos = r_s;
                end
            end
            S_FILL_CHK: begin
                n_j = pos_lt_n ? r_pos[SLOT_W-1:0] : '0;
            end
            S_FILL: begin
                s_we = 1'b1;
                n_j  = (j_inc == r_n) ? '0 : j_inc[SLOT_W-1:0];
            end
            S_EMIT_RD: ;
            S_EMIT_LD: begin
                if (out_load) begin
                    n_out_vld        = 1'b1;
                    n_out.level      = s_rd;
                    n_out.slot_index = r_j;
                    n_out.last_slot  = (j_inc == r_n);
                    n_j              = j_inc[SLOT_W-1:0];
                end
            end
            default: ;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_SAMPLES: begin
                    n_bs    = i_cfg_data[BS_W-1:0];
                    n_head  = '0;
                    n_count = '0;
                end
                CFG_PERIOD: n_per = i_cfg_data[PER_W-1:0];
                CFG_INIT_LEVEL: begin
                    n_init = i_cfg_data;
                    n_cur  = i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bs      <= BS_W'(512);
            r_per     <= PER_W'(8);
            r_init    <= '0;
            r_cur     <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bs      <= n_bs;
            r_per     <= n_per;
            r_init    <= n_init;
            r_cur     <= n_cur;
            r_head    <= n_head;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_n   <= n_n;
        r_j   <= n_j;
        r_k   <= n_k;
        r_s   <= n_s;
        r_v   <= n_v;
        r_out <= n_out;
    end

    brm_sdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    brm_mac u_mac (
        .i_clk  (i_clk),
        .i_clr  (mac_clr),
        .i_step (div_stat.step),
        .i_qbit (div_stat.qbit),
        .i_diff (mac_diff),
        .o_acc  (mac_acc)
    );

    brm_ram #(
        .WIDTH (QENT_W),
        .DEPTH (POINT_DEPTH)
    ) u_queue (
        .i_clk (i_clk),
        .i_we  (q_we),
        .i_wa  (q_wa),
        .i_wd  ({div_stat.quot[POS_W-1:0], r_v}),
        .i_ra  (r_head),
        .o_rd  (q_rd)
    );

    brm_ram #(
        .WIDTH (LVL_W),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .i_clk (i_clk),
        .i_we  (s_we),
        .i_wa  (r_j),
        .i_wd  (s_wd),
        .i_ra  (r_j),
        .o_rd  (s_rd)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(POINT_DEPTH))
        else $error("queue count beyond depth");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> ({1'b0, r_j} < r_n))
        else $error("slot read out beyond slot count");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_ADD_DIV || r_state == S_CNT_DIV ||
                           r_state == S_SLOT_DIV))
        else $error("divider finished outside a wait state");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_stat.step)
        else $error("divider started while busy");

endmodule

`default_nettype wire
